[hdl/framed_packet_checksum_check_top_macros.svh]
// Assertion macros shared by the checker.
`ifndef FRAMED_PACKET_CHECKSUM_CHECK_TOP_MACROS_SVH
`define FRAMED_PACKET_CHECKSUM_CHECK_TOP_MACROS_SVH

// same-cycle implication
`define FPCC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fpcc assertion failed");

// next-cycle implication
`define FPCC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fpcc assertion failed");

`endif

[hdl/fpcc_pkg.sv]
`default_nettype none
package fpcc_pkg;

  localparam logic [15:0] SUM_SEED       = 16'hAAAA;
  localparam int          HEADER_BYTES   = 14;
  localparam int          CHECK_BYTES    = 2;
  localparam int          FRAME_OVERHEAD = HEADER_BYTES + CHECK_BYTES;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;
  localparam logic [1:0] STATUS_OVERLONG = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] payload_length;
    logic [15:0] computed_sum;
  } out_t;

  // xor then rotate left by one
  function automatic logic [15:0] fold_word(input logic [15:0] sum, input logic [15:0] word);
    logic [15:0] x;
    x = sum ^ word;
    return {x[14:0], x[15]};
  endfunction

endpackage
`default_nettype wire

[hdl/framed_packet_checksum_check_top.sv]
// channel | dir | handshake           | payload
// pkt     | in  | pkt_valid/pkt_stall | fpcc_pkg::in_t  (byte_value, last_byte)
// res     | out | res_valid/res_stall | fpcc_pkg::out_t (status, payload_length, computed_sum)
//
// One byte per cycle while pkt_stall is low; the result shows on res in the cycle after the last byte's transfer.
// Per-byte fold and status are one pass of logic ahead of the result register.
// rst is synchronous and clears the running sum to its seed and all counts.
// pkt_stall is high only while a result waits in the output register and res_stall is high.
`default_nettype none
module framed_packet_checksum_check_top #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pkt_valid,
  output logic                pkt_stall,
  input  wire fpcc_pkg::in_t  pkt,
  output logic                res_valid,
  input  wire logic           res_stall,
  output fpcc_pkg::out_t      res
);

  logic           ready;
  logic           take;
  fpcc_pkg::out_t result;

  assign pkt_stall = !ready;
  assign take      = pkt_valid && ready;

  fpcc_accum #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (pkt),
    .result(result)
  );

  fpcc_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (take && pkt.last_byte),
    .din  (result),
    .stall(res_stall),
    .valid(res_valid),
    .dout (res),
    .ready(ready)
  );

endmodule
`default_nettype wire

[hdl/fpcc_accum.sv]
`default_nettype none
module fpcc_accum #(
  parameter int MAX_PACKET_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire fpcc_pkg::in_t item,
  output fpcc_pkg::out_t     result
);

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [15:0]   running_sum, running_sum_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   delay_bytes, delay_bytes_next;
  logic [7:0]    pending_low_byte, pending_low_byte_next;
  logic          word_phase, word_phase_next;
  logic          overlong_flag, overlong_flag_next;

  logic [15:0] sum_step;
  logic [7:0]  pend_step;
  logic        phase_step;
  logic        ovf_step;
  logic [CW-1:0] count_step;
  logic [15:0] final_sum;
  logic [15:0] recv;

  always_comb begin
    ovf_step   = overlong_flag;
    count_step = byte_count;
    if (byte_count == CW'(MAX_PACKET_BYTES)) begin
      ovf_step = 1'b1;
    end else begin
      count_step = byte_count + CW'(1);
    end

    sum_step   = running_sum;
    pend_step  = pending_low_byte;
    phase_step = word_phase;
    if (byte_count >= CW'(2)) begin
      if (!word_phase) begin
        pend_step  = delay_bytes[15:8];
        phase_step = 1'b1;
      end else begin
        sum_step   = fpcc_pkg::fold_word(running_sum, {delay_bytes[15:8], pending_low_byte});
        phase_step = 1'b0;
      end
    end

    recv      = {item.byte_value, delay_bytes[7:0]};
    final_sum = phase_step ? fpcc_pkg::fold_word(sum_step, {8'h00, pend_step}) : sum_step;

    result.computed_sum   = final_sum;
    result.payload_length = 12'd0;
    if (ovf_step) begin
      result.status = fpcc_pkg::STATUS_OVERLONG;
    end else if (count_step <= CW'(fpcc_pkg::FRAME_OVERHEAD)) begin
      result.status = fpcc_pkg::STATUS_SHORT;
    end else if (recv != final_sum) begin
      result.status = fpcc_pkg::STATUS_BAD_SUM;
    end else begin
      result.status         = fpcc_pkg::STATUS_OK;
      result.payload_length = 12'(count_step - CW'(fpcc_pkg::FRAME_OVERHEAD));
    end

    running_sum_next      = running_sum;
    byte_count_next       = byte_count;
    delay_bytes_next      = delay_bytes;
    pending_low_byte_next = pending_low_byte;
    word_phase_next       = word_phase;
    overlong_flag_next    = overlong_flag;
    if (take) begin
      if (item.last_byte) begin
        running_sum_next      = fpcc_pkg::SUM_SEED;
        byte_count_next       = '0;
        delay_bytes_next      = '0;
        pending_low_byte_next = '0;
        word_phase_next       = 1'b0;
        overlong_flag_next    = 1'b0;
      end else begin
        running_sum_next      = sum_step;
        byte_count_next       = count_step;
        delay_bytes_next      = {delay_bytes[7:0], item.byte_value};
        pending_low_byte_next = pend_step;
        word_phase_next       = phase_step;
        overlong_flag_next    = ovf_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum      <= fpcc_pkg::SUM_SEED;
      byte_count       <= '0;
      delay_bytes      <= '0;
      pending_low_byte <= '0;
      word_phase       <= 1'b0;
      overlong_flag    <= 1'b0;
    end else begin
      running_sum      <= running_sum_next;
      byte_count       <= byte_count_next;
      delay_bytes      <= delay_bytes_next;
      pending_low_byte <= pending_low_byte_next;
      word_phase       <= word_phase_next;
      overlong_flag    <= overlong_flag_next;
    end
  end

endmodule
`default_nettype wire

[hdl/fpcc_out_reg.sv]
`default_nettype none
module fpcc_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire fpcc_pkg::out_t din,
  input  wire logic           stall,
  output logic                valid,
  output fpcc_pkg::out_t      dout,
  output logic                ready
);

  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
`default_nettype wire

[hdl/fpcc_checker.sv]
`default_nettype none
`include "framed_packet_checksum_check_top_macros.svh"
module fpcc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           pkt_valid,
  input wire logic           pkt_stall,
  input wire fpcc_pkg::in_t  pkt,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire fpcc_pkg::out_t res
);

  `FPCC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
  `FPCC_ASSERT_NOW(a_stall_only_when_full, pkt_stall, res_valid && res_stall)
  `FPCC_ASSERT_NOW(a_res_from_last, res_valid && !$past(res_valid), $past(pkt_valid && !pkt_stall && pkt.last_byte))
  `FPCC_ASSERT_NOW(a_len_zero_unless_ok, res_valid && (res.status != fpcc_pkg::STATUS_OK), res.payload_length == 12'd0)

endmodule

bind framed_packet_checksum_check_top fpcc_checker u_chk (.*);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int MAXB = 4096;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           pkt_valid = 1'b0;
  logic           pkt_stall;
  fpcc_pkg::in_t  pkt = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  fpcc_pkg::out_t res;

  framed_packet_checksum_check_top #(
    .MAX_PACKET_BYTES(MAXB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt(pkt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  fpcc_pkg::in_t  pend_bytes[$];
  fpcc_pkg::out_t exp_results[$];
  fpcc_pkg::out_t want;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;
  int   errors = 0;
  int   queued_bytes = 0;

  logic [15:0] rx_sum = fpcc_pkg::SUM_SEED;
  int          rx_count = 0;
  logic [15:0] rx_delay = '0;
  logic [7:0]  rx_low = '0;
  logic        rx_half = 1'b0;
  logic        rx_over = 1'b0;

  function automatic logic [15:0] rot_fold(logic [15:0] s, logic [15:0] w);
    logic [15:0] x;
    x = s ^ w;
    return (x << 1) | (x >> 15);
  endfunction

  // running checksum over a received frame; queues the verdict on the last byte
  function automatic void fold_rx_byte(fpcc_pkg::in_t it);
    int             prior;
    logic [15:0]    sum;
    logic [15:0]    recv;
    fpcc_pkg::out_t r;
    prior = rx_count;
    if (prior >= MAXB) rx_over = 1'b1;
    else rx_count = prior + 1;
    if (prior >= 2) begin
      if (!rx_half) begin
        rx_low = rx_delay[15:8];
        rx_half = 1'b1;
      end else begin
        rx_sum = rot_fold(rx_sum, {rx_delay[15:8], rx_low});
        rx_half = 1'b0;
      end
    end
    recv = {it.byte_value, rx_delay[7:0]};
    rx_delay = {rx_delay[7:0], it.byte_value};
    if (it.last_byte) begin
      sum = rx_half ? rot_fold(rx_sum, {8'h00, rx_low}) : rx_sum;
      r.computed_sum = sum;
      r.payload_length = '0;
      if (rx_over) begin
        r.status = fpcc_pkg::STATUS_OVERLONG;
      end else if (rx_count <= fpcc_pkg::FRAME_OVERHEAD) begin
        r.status = fpcc_pkg::STATUS_SHORT;
      end else if (recv != sum) begin
        r.status = fpcc_pkg::STATUS_BAD_SUM;
      end else begin
        r.status = fpcc_pkg::STATUS_OK;
        r.payload_length = 12'(rx_count - fpcc_pkg::FRAME_OVERHEAD);
      end
      exp_results = {exp_results, r};
      rx_sum = fpcc_pkg::SUM_SEED;
      rx_count = 0;
      rx_delay = '0;
      rx_low = '0;
      rx_half = 1'b0;
      rx_over = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else begin
      if (pkt_valid && !pkt_stall) fold_rx_byte(pkt);
      if (!pkt_valid || !pkt_stall) begin
        if (pend_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pkt <= pend_bytes.pop_front();
          pkt_valid <= 1'b1;
        end else begin
          pkt_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt <= HOLD_CYCLES;
      res_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (exp_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", res);
      end else begin
        want = exp_results.pop_front();
        if (res.status !== want.status || res.payload_length !== want.payload_length ||
            res.computed_sum !== want.computed_sum) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: status exp %0d got %0d, length exp %0d got %0d,",
                     want.status, res.status, want.payload_length, res.payload_length);
            $display("          sum exp %h got %h", want.computed_sum, res.computed_sum);
          end
        end
      end
    end
  end

  task automatic queue_packet(int n, fill_t fill, bit good);
    logic [7:0]    b[$];
    logic [15:0]   s;
    logic [7:0]    v;
    fpcc_pkg::in_t it;
    s = fpcc_pkg::SUM_SEED;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZEROS: v = 8'h00;
        FILL_ONES:  v = 8'hFF;
        default:    v = 8'($urandom);
      endcase
      b = {b, v};
    end
    for (int i = 0; i < n - 2; i += 2) begin
      s = rot_fold(s, {(i + 1 < n - 2) ? b[i + 1] : 8'h00, b[i]});
    end
    if (good && n >= 2) begin
      b[n - 2] = s[7:0];
      b[n - 1] = s[15:8];
    end
    for (int i = 0; i < n; i++) begin
      it.byte_value = b[i];
      it.last_byte = (i == n - 1);
      pend_bytes = {pend_bytes, it};
      queued_bytes++;
    end
  endtask

  task automatic random_packet();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 15) n = $urandom_range(16, 1);
    else if (r < 85) n = $urandom_range(48, 17);
    else n = $urandom_range(300, 49);
    queue_packet(n, FILL_RANDOM, $urandom_range(3) != 0);
  endtask

  task automatic wait_drained();
    while (pend_bytes.size() > 0 || pkt_valid || exp_results.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    stall_pct = stall;
    queued_bytes = 0;
    while (queued_bytes < count) random_packet();
    wait_drained();
  endtask

  initial begin
    #5_000_000;
    $display("[framed_packet_checksum_check_top] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_packet(1, FILL_ONES, 0);
    queue_packet(2, FILL_ZEROS, 0);
    queue_packet(3, FILL_ONES, 0);
    queue_packet(17, FILL_ONES, 1);
    wait_drained();

    random_phase(0, 0, 250);
    random_phase(54, 0, 250);
    random_phase(0, 54, 250);
    random_phase(31, 31, 250);

    // long receiver hold-off while frames keep coming
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 10; i++) queue_packet($urandom_range(24, 17), FILL_RANDOM, 1);
    wait_drained();

    random_phase(0, 0, 50);

    repeat (20) @(posedge clk);
    errors += exp_results.size();
    if (errors == 0) begin
      $display("[framed_packet_checksum_check_top] OK");
    end else begin
      $display("[framed_packet_checksum_check_top] ERROR");
    end
    $finish;
  end

endmodule
